@@ rtl/tgq_pkg.sv @@
// Shared types, constants and helpers of the text glyph quad generator.
package tgq_pkg;

  localparam int PEN_W      = 14;
  localparam int SCALE_W    = 11;
  localparam int WIN_W      = 13;
  localparam int CODE_W     = 8;
  localparam int VTX_W      = 24;
  localparam int TEX_W      = 5;
  localparam int SUM_W      = PEN_W + SCALE_W + 1;
  localparam int DX_W       = SCALE_W + 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int GLYPH_HEIGHT_DEF = 16;
  localparam int CMD_DEPTH_DEF    = 2;
  localparam int OUT_DEPTH_DEF    = 2;

  localparam int ADV_NARROW = 7;
  localparam int ADV_WIDE   = 14;

  localparam logic [CODE_W-1:0] CHAR_FIRST = 8'h20;
  localparam logic [CODE_W-1:0] CHAR_LAST  = 8'h7F;
  localparam logic [CODE_W-1:0] CHAR_LOW   = 8'h40;
  localparam logic [CODE_W-1:0] CHAR_MID   = 8'h60;
  localparam logic [CODE_W-1:0] OFS_HIGH   = 8'h80;
  localparam logic [CODE_W-1:0] OFS_MID    = 8'h40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_H    = 3'd4;

  localparam logic [SCALE_W-1:0] SCALE_RST = 11'd256;
  localparam logic [WIN_W-1:0]   WIN_H_RST = 13'd1080;

  // Vertex order of the quad: bit i picks the right column / bottom row for vertex i.
  localparam int          VTX_PER_QUAD = 6;
  localparam logic [5:0]  VTX_SEL_X    = 6'b010110;
  localparam logic [5:0]  VTX_SEL_Y    = 6'b110100;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic               narrow;
    logic               flip;
    logic [WIN_W-1:0]   win_h;
  } cfg_t;

  typedef struct packed {
    logic signed [PEN_W-1:0] pen_col;
    logic signed [PEN_W-1:0] pen_row;
    logic [CODE_W-1:0]       code;
  } cmd_t;

  typedef struct packed {
    logic signed [VTX_W-1:0] x;
    logic signed [VTX_W-1:0] y;
    logic [TEX_W-1:0]        s;
    logic [TEX_W-1:0]        t;
    logic                    last;
  } vtx_t;

  // Move a printable byte into the glyph sheet.
  function automatic logic [CODE_W-1:0] remap(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] r;
    if (c < CHAR_LOW) r = c + OFS_HIGH;
    else if (c < CHAR_MID) r = c + OFS_MID;
    else r = c + OFS_HIGH;
    return r;
  endfunction

  // Clamp to the signed vertex range.
  function automatic logic signed [VTX_W-1:0] sat_vtx(input logic signed [SUM_W-1:0] v);
    logic signed [VTX_W-1:0] r;
    if (v[SUM_W-1:VTX_W-1] == '0 || v[SUM_W-1:VTX_W-1] == '1) r = v[VTX_W-1:0];
    else if (v[SUM_W-1]) r = {1'b1, {(VTX_W-1){1'b0}}};
    else r = {1'b0, {(VTX_W-1){1'b1}}};
    return r;
  endfunction

endpackage

@@ rtl/tgq_fifo.sv @@
// Small synchronous queue with first-word fall-through read.
module tgq_fifo import tgq_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_P) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_P) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/tgq_front.sv @@
// Front end: takes characters, tracks the pen and skip flag, queues drawable glyphs.
module tgq_front import tgq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    push,
  input  logic                    new_text,
  input  logic signed [PEN_W-1:0] start_x,
  input  logic signed [PEN_W-1:0] start_y,
  input  logic [CODE_W-1:0]       char_code,
  input  logic                    cmd_full,
  output logic                    cmd_push,
  output cmd_t                    cmd_data
);

  logic signed [PEN_W-1:0] pen_col;
  logic signed [PEN_W-1:0] pen_row;
  logic                    skip_text;

  logic                    accept;
  logic signed [PEN_W-1:0] col_eff;
  logic signed [PEN_W-1:0] row_eff;
  logic                    skip_eff;
  logic                    printable;
  logic                    draw;
  logic signed [PEN_W:0]   adv;
  logic signed [PEN_W:0]   pen_sum;
  logic signed [PEN_W-1:0] pen_col_next;

  always_comb begin
    accept    = push & ~cmd_full;
    col_eff   = new_text ? start_x : pen_col;
    row_eff   = new_text ? start_y : pen_row;
    skip_eff  = new_text ? (start_y[PEN_W-1] || (start_y > $signed({1'b0, cfg.win_h})))
                         : skip_text;
    printable = (char_code >= CHAR_FIRST) && (char_code <= CHAR_LAST);
    draw      = ~skip_eff & printable;
    adv       = cfg.narrow ? (PEN_W+1)'(ADV_NARROW) : (PEN_W+1)'(ADV_WIDE);
    pen_sum   = {col_eff[PEN_W-1], col_eff} + adv;
    // advance is positive, so only the top end can overflow
    if (pen_sum[PEN_W] != pen_sum[PEN_W-1]) begin
      pen_col_next = {1'b0, {(PEN_W-1){1'b1}}};
    end else begin
      pen_col_next = pen_sum[PEN_W-1:0];
    end
  end

  assign cmd_push         = accept & draw;
  assign cmd_data.pen_col = col_eff;
  assign cmd_data.pen_row = row_eff;
  assign cmd_data.code    = remap(char_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_col   <= '0;
      pen_row   <= '0;
      skip_text <= 1'b0;
    end else if (accept) begin
      pen_col   <= draw ? pen_col_next : col_eff;
      pen_row   <= row_eff;
      skip_text <= skip_eff;
    end
  end

endmodule

@@ rtl/tgq_back.sv @@
// Back end: scales the pen, builds the quad corners and sends out six vertices.
module tgq_back import tgq_pkg::*; #(
  parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cmd_empty,
  input  cmd_t cmd_data,
  output logic cmd_pop,
  input  logic out_full,
  output logic out_push,
  output vtx_t out_data
);

  localparam int DY_W = SCALE_W + $clog2(GLYPH_HEIGHT + 1);
  localparam logic [2:0] LAST_VTX = 3'(VTX_PER_QUAD - 1);

  // product stage
  logic                    p_v;
  logic signed [SUM_W-1:0] p_x0;
  logic signed [SUM_W-1:0] p_y0;
  logic [DX_W-1:0]         p_dx;
  logic [DY_W-1:0]         p_dy;
  logic [CODE_W-1:0]       p_code;

  // quad register and vertex sequencer
  logic                    q_v;
  logic [2:0]              vcnt;
  logic signed [VTX_W-1:0] q_x0, q_x1, q_y0, q_y1;
  logic [TEX_W-1:0]        q_s0, q_s1, q_t0, q_t1;

  logic                    emit;
  logic                    q_done;
  logic                    q_load;
  logic                    p_load_ok;
  logic [DX_W-1:0]         sx_ext;
  logic [DX_W-1:0]         dx7;
  logic signed [SUM_W-1:0] x1_sum;
  logic signed [SUM_W-1:0] y1_sum;
  logic [TEX_W-1:0]        col5;
  logic [TEX_W-1:0]        row5;

  always_comb begin
    emit      = q_v & ~out_full;
    q_done    = emit && (vcnt == LAST_VTX);
    q_load    = p_v && (!q_v || q_done);
    p_load_ok = !p_v || q_load;
    cmd_pop   = !cmd_empty && p_load_ok;
    sx_ext    = DX_W'(cfg.scale_x);
    dx7       = (sx_ext << 3) - sx_ext;
    x1_sum    = p_x0 + $signed(SUM_W'(p_dx));
    y1_sum    = p_y0 + $signed(SUM_W'(p_dy));
    col5      = TEX_W'(p_code[3:0]);
    row5      = TEX_W'(p_code[7:4]);
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      p_x0   <= cmd_data.pen_col * $signed({1'b0, cfg.scale_x});
      p_y0   <= cmd_data.pen_row * $signed({1'b0, cfg.scale_y});
      p_dx   <= cfg.narrow ? dx7 : (dx7 << 1);
      p_dy   <= DY_W'(cfg.scale_y) * DY_W'(GLYPH_HEIGHT);
      p_code <= cmd_data.code;
    end
    if (q_load) begin
      q_x0 <= sat_vtx(p_x0);
      q_x1 <= sat_vtx(x1_sum);
      q_y0 <= sat_vtx(p_y0);
      q_y1 <= sat_vtx(y1_sum);
      q_s0 <= col5;
      q_s1 <= col5 + 1'b1;
      q_t0 <= cfg.flip ? row5 + 1'b1 : row5;
      q_t1 <= cfg.flip ? row5 : row5 + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v  <= 1'b0;
      q_v  <= 1'b0;
      vcnt <= '0;
    end else begin
      if (cmd_pop) begin
        p_v <= 1'b1;
      end else if (q_load) begin
        p_v <= 1'b0;
      end
      if (q_load) begin
        q_v  <= 1'b1;
        vcnt <= '0;
      end else if (q_done) begin
        q_v  <= 1'b0;
        vcnt <= '0;
      end else if (emit) begin
        vcnt <= vcnt + 1'b1;
      end
    end
  end

  assign out_push      = emit;
  assign out_data.x    = VTX_SEL_X[vcnt] ? q_x1 : q_x0;
  assign out_data.y    = VTX_SEL_Y[vcnt] ? q_y1 : q_y0;
  assign out_data.s    = VTX_SEL_X[vcnt] ? q_s1 : q_s0;
  assign out_data.t    = VTX_SEL_Y[vcnt] ? q_t1 : q_t0;
  assign out_data.last = (vcnt == LAST_VTX);

endmodule

@@ rtl/text_glyph_quad_generator_top.sv @@
// Top level of the text glyph quad generator: config registers, front, queues, back.
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------------
//  input   | push / full             | new_text, start_x, start_y, char_code
//  result  | empty / pop             | vertex_x, vertex_y, tex_s, tex_t, last_vertex
//  config  | cfg_we (no wait)        | cfg_index, cfg_data
//
// One character transfer per cycle while the command queue has room. Skipped and
// non-printable characters only update pen state and take no queue slot.
// A drawn glyph holds the vertex sequencer for its six vertices, one vertex per cycle
// while the output queue has room; the next glyph loads as the last vertex goes out.
// First vertex passes the command queue, product stage, quad register and output queue.
// rst is synchronous and clears pen, skip flag, queues and registers to defaults.
// A stalled result side fills the output queue, then the command queue, then full rises.
module text_glyph_quad_generator_top import tgq_pkg::*; #(
  parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
  parameter int CMD_DEPTH    = CMD_DEPTH_DEF,
  parameter int OUT_DEPTH    = OUT_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // config write port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // character input
  input  logic                    push,
  output logic                    full,
  input  logic                    new_text,
  input  logic signed [PEN_W-1:0] start_x,
  input  logic signed [PEN_W-1:0] start_y,
  input  logic [CODE_W-1:0]       char_code,
  // vertex output
  output logic                    empty,
  input  logic                    pop,
  output logic signed [VTX_W-1:0] vertex_x,
  output logic signed [VTX_W-1:0] vertex_y,
  output logic [TEX_W-1:0]        tex_s,
  output logic [TEX_W-1:0]        tex_t,
  output logic                    last_vertex
);

  cfg_t cfg;

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_head;
  logic cmd_empty;

  logic out_push;
  vtx_t out_in;
  logic out_full;
  vtx_t out_head;

  // Config registers; the user must write them only while the block is idle, not enforced here.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_x <= SCALE_RST;
      cfg.scale_y <= SCALE_RST;
      cfg.narrow  <= 1'b0;
      cfg.flip    <= 1'b0;
      cfg.win_h   <= WIN_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_X: cfg.scale_x <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y: cfg.scale_y <= cfg_data[SCALE_W-1:0];
        REG_NARROW:  cfg.narrow  <= cfg_data[0];
        REG_FLIP:    cfg.flip    <= cfg_data[0];
        REG_WIN_H:   cfg.win_h   <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input side stalls only on the command queue
  assign full = cmd_full;

  tgq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .new_text  (new_text),
    .start_x   (start_x),
    .start_y   (start_y),
    .char_code (char_code),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in)
  );

  tgq_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  tgq_back #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_in)
  );

  // output queue decouples the vertex sequencer from the consumer
  tgq_fifo #(
    .WIDTH ($bits(vtx_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_in),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_head),
    .empty (empty)
  );

  assign vertex_x    = out_head.x;
  assign vertex_y    = out_head.y;
  assign tex_s       = out_head.s;
  assign tex_t       = out_head.t;
  assign last_vertex = out_head.last;

endmodule

@@ rtl/tgq_checker.sv @@
// Port-level checks of the text glyph quad generator, bound to the top level.
module tgq_checker import tgq_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    full,
  input logic                    empty,
  input logic                    pop,
  input logic signed [VTX_W-1:0] vertex_x,
  input logic signed [VTX_W-1:0] vertex_y,
  input logic [TEX_W-1:0]        tex_s,
  input logic [TEX_W-1:0]        tex_t,
  input logic                    last_vertex
);

  // reset drains both queues
  a_rst_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not drained by reset");

  // a waiting vertex holds until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(vertex_x) && $stable(vertex_y) &&
      $stable(tex_s) && $stable(tex_t) && $stable(last_vertex))
    else $error("waiting vertex changed");

  // glyph sheet rows of printable text lie in the lower half
  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> tex_t >= 5'd8 && tex_t <= 5'd16 && tex_s <= 5'd16)
    else $error("texture coordinate out of sheet");

  // the closing vertex uses the left column
  a_last_left: assert property (@(posedge clk) disable iff (rst)
    !empty && last_vertex |-> tex_s != 5'd16)
    else $error("last vertex on right column");

endmodule

bind text_glyph_quad_generator_top tgq_checker u_tgq_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the text glyph quad generator top level.
module tb_top;
  import tgq_pkg::*;

  localparam int SETTLE      = 8;     // cycles for pen-only items to clear the front end
  localparam int STALL_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int PEN_TOP     = (1 << (PEN_W - 1)) - 1;
  localparam int VTX_TOP     = (1 << (VTX_W - 1)) - 1;
  localparam int VTX_BOT     = -(1 << (VTX_W - 1));
  localparam int NDIR        = 26;
  localparam int ITEMS_PER_PHASE = 74;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    push = 1'b0;
  logic                    full;
  logic                    new_text = 1'b0;
  logic signed [PEN_W-1:0] start_x = '0;
  logic signed [PEN_W-1:0] start_y = '0;
  logic [CODE_W-1:0]       char_code = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic signed [VTX_W-1:0] vertex_x;
  logic signed [VTX_W-1:0] vertex_y;
  logic [TEX_W-1:0]        tex_s;
  logic [TEX_W-1:0]        tex_t;
  logic                    last_vertex;

  text_glyph_quad_generator_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .new_text   (new_text),
    .start_x    (start_x),
    .start_y    (start_y),
    .char_code  (char_code),
    .empty      (empty),
    .pop        (pop),
    .vertex_x   (vertex_x),
    .vertex_y   (vertex_y),
    .tex_s      (tex_s),
    .tex_t      (tex_t),
    .last_vertex(last_vertex)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed stimulus row. cfg >= 0 loads that register preset (block drained first).
  // Where typed is set, count and first vertex are known by hand and cross-check the
  // predictor; every row is also checked vertex by vertex against the predictor.
  typedef struct {
    int cfg;
    bit nt;
    int sx;
    int sy;
    int cc;
    bit typed;
    int n;
    int x0;
    int y0;
    int s0;
    int t0;
  } dir_row_t;

  cfg_t cfg_presets [4] = '{
    '{SCALE_RST, SCALE_RST, 1'b0, 1'b0, WIN_H_RST},   // reset values
    '{11'd2047, 11'd2047, 1'b1, 1'b1, 13'd0},         // top scale, narrow, flip, row 0 only
    '{11'd0, 11'd0, 1'b0, 1'b0, 13'd8191},            // collapsed quad, widest window
    '{11'd1024, 11'd1024, 1'b1, 1'b0, 13'd8191}       // top of nominal scale range
  };

  //                cfg nt     sx     sy    cc typ n        x0      y0  s0  t0
  dir_row_t dir_tbl [NDIR] = '{
    '{ 0, 1,     0,     0, 'h41, 1, 6,        0,      0,  1,  8},  // 'A' at origin
    '{-1, 0,     0,     0, 'h20, 1, 6,     3584,      0,  0, 10},  // first printable
    '{-1, 0,     0,     0, 'h7F, 1, 6,     7168,      0, 15, 15},  // last printable
    '{-1, 0,     0,     0, 'h1F, 1, 0,        0,      0,  0,  0},  // just below printable
    '{-1, 0,     0,     0, 'h80, 1, 0,        0,      0,  0,  0},  // just above printable
    '{-1, 0,     0,     0, 'hFF, 1, 0,        0,      0,  0,  0},
    '{-1, 0,     0,     0, 'h00, 1, 0,        0,      0,  0,  0},
    '{-1, 0,     0,     0, 'h3F, 1, 6,    10752,      0, 15, 11},  // top of +0x80 band
    '{-1, 0,     0,     0, 'h40, 1, 6,    14336,      0,  0,  8},  // bottom of +0x40 band
    '{-1, 0,     0,     0, 'h5F, 1, 6,    17920,      0, 15,  9},
    '{-1, 0,     0,     0, 'h60, 1, 6,    21504,      0,  0, 14},
    '{-1, 1,     5,    -1, 'h41, 1, 0,        0,      0,  0,  0},  // row above window
    '{-1, 0,     0,     0, 'h42, 1, 0,        0,      0,  0,  0},  // rest of skipped text
    '{-1, 1,     5,  1081, 'h41, 1, 0,        0,      0,  0,  0},  // row past height
    '{-1, 1, -8192,  1080, 'h41, 1, 6, -2097152, 276480,  1,  8},  // row on the bound
    '{-1, 1,  8191,     0, 'h41, 1, 6,  2096896,      0,  1,  8},
    '{-1, 0,     0,     0, 'h41, 1, 6,  2096896,      0,  1,  8},  // pen held at its top
    '{-1, 1, -8192, -8192, 'h41, 1, 0,        0,      0,  0,  0},
    '{-1, 1,  8191,  8191, 'h41, 1, 0,        0,      0,  0,  0},
    '{-1, 1,    10,    10, 'h0A, 1, 0,        0,      0,  0,  0},  // new text, no glyph
    '{-1, 0,     0,     0, 'h21, 0, 0,        0,      0,  0,  0},
    '{ 1, 1,  8191,     0, 'h41, 1, 6,  8388607,      0,  1,  9},  // x clamps high, flip
    '{-1, 1, -8192,     0, 'h41, 1, 6, -8388608,      0,  1,  9},  // x clamps low
    '{-1, 1,     0,     1, 'h41, 1, 0,        0,      0,  0,  0},  // zero height window
    '{ 2, 1,  1234,  8191, 'h7F, 1, 6,        0,      0, 15, 15},  // zero scale
    '{ 3, 1,  8191,  8191, 'h20, 0, 0,        0,      0,  0,  0}   // both axes clamp
  };

  // Predictor state: shadow registers and pen.
  cfg_t                    cfg_now;
  logic signed [PEN_W-1:0] pen_x;
  logic signed [PEN_W-1:0] pen_y;
  bit                      text_skipped;
  vtx_t                    quad_head;          // first vertex of the latest glyph

  vtx_t     vertices_due [$];                  // predicted vertices not yet transferred
  dir_row_t table_rows_sent [$];               // directed rows awaiting their transfer
  int       err_count;
  int       quiet_cycles;
  int       send_idle_pct;
  int       recv_idle_pct;

  function automatic logic signed [VTX_W-1:0] clamp_vtx(longint v);
    if (v > VTX_TOP) return VTX_W'(VTX_TOP);
    if (v < VTX_BOT) return VTX_W'(VTX_BOT);
    return VTX_W'(v);
  endfunction

  // Works out the glyph quad for one character transfer; returns the vertex count.
  function automatic int predict_glyph(bit nt, logic signed [PEN_W-1:0] sx,
                                       logic signed [PEN_W-1:0] sy, logic [CODE_W-1:0] cc);
    logic [CODE_W-1:0]       cell_code;
    logic [TEX_W-1:0]        s_left, t_top, t_bot;
    logic signed [VTX_W-1:0] x_left, x_right, y_top, y_bot;
    longint                  xl, yt;
    int                      adv, nxt;
    bit                      right, lower;
    vtx_t                    v;
    if (nt) begin
      pen_x = sx;
      pen_y = sy;
      text_skipped = (int'(sy) < 0) || (int'(sy) > int'(cfg_now.win_h));
    end
    if (text_skipped || cc < CHAR_FIRST || cc > CHAR_LAST) return 0;
    cell_code = cc + ((cc >= CHAR_LOW && cc < CHAR_MID) ? OFS_MID : OFS_HIGH);
    s_left = TEX_W'(cell_code[3:0]);
    t_top  = TEX_W'(cell_code[7:4]);
    t_bot  = t_top + 1'b1;
    if (cfg_now.flip) begin
      t_top = t_bot;
      t_bot = TEX_W'(cell_code[7:4]);
    end
    adv     = cfg_now.narrow ? ADV_NARROW : ADV_WIDE;
    xl      = longint'(pen_x) * longint'(cfg_now.scale_x);
    yt      = longint'(pen_y) * longint'(cfg_now.scale_y);
    x_left  = clamp_vtx(xl);
    x_right = clamp_vtx(xl + longint'(adv) * longint'(cfg_now.scale_x));
    y_top   = clamp_vtx(yt);
    y_bot   = clamp_vtx(yt + longint'(GLYPH_HEIGHT_DEF) * longint'(cfg_now.scale_y));
    // two triangles: TL TR BR, TL BR BL
    for (int k = 0; k < VTX_PER_QUAD; k++) begin
      right  = (k == 1) || (k == 2) || (k == 4);
      lower  = (k == 2) || (k == 4) || (k == 5);
      v.x    = right ? x_right : x_left;
      v.y    = lower ? y_bot : y_top;
      v.s    = right ? s_left + 1'b1 : s_left;
      v.t    = lower ? t_bot : t_top;
      v.last = (k == VTX_PER_QUAD - 1);
      if (k == 0) quad_head = v;
      vertices_due = {vertices_due, v};
    end
    nxt = int'(pen_x) + adv;
    if (nxt > PEN_TOP) nxt = PEN_TOP;
    pen_x = PEN_W'(nxt);
    return VTX_PER_QUAD;
  endfunction

  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_count++;
    end
  endfunction

  // Result side: random stalls on pop, one decision per cycle.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Transfer monitor: runs the predictor on each character transfer, checks each
  // vertex transfer against the oldest prediction, and watches for a hung block.
  always @(posedge clk) begin : monitor
    vtx_t     want;
    dir_row_t row;
    int       n;
    bit       moved;
    if (!rst) begin
      moved = 1'b0;
      // vertex side first: a pop here can only belong to an earlier character
      if (pop && !empty) begin
        moved = 1'b1;
        if (vertices_due.size() == 0) begin
          $display("%0t: vertex transfer with none expected, actual x %0d y %0d",
                   $time, vertex_x, vertex_y);
          err_count++;
        end else begin
          want = vertices_due.pop_front();
          check_field("vertex_x", longint'($signed(want.x)), longint'($signed(vertex_x)));
          check_field("vertex_y", longint'($signed(want.y)), longint'($signed(vertex_y)));
          check_field("tex_s", want.s, tex_s);
          check_field("tex_t", want.t, tex_t);
          check_field("last_vertex", want.last, last_vertex);
        end
      end
      if (push && !full) begin
        moved = 1'b1;
        n = predict_glyph(new_text, start_x, start_y, char_code);
        if (table_rows_sent.size() != 0) begin
          row = table_rows_sent.pop_front();
          if (row.typed) begin
            check_field("table vertex count", row.n, n);
            if (row.n != 0 && n != 0) begin
              check_field("table x0", row.x0, longint'($signed(quad_head.x)));
              check_field("table y0", row.y0, longint'($signed(quad_head.y)));
              check_field("table s0", row.s0, quad_head.s);
              check_field("table t0", row.t0, quad_head.t);
            end
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // One character transfer; the sender may idle first, push stays high across back-to-back items.
  task automatic send_char(bit nt, logic signed [PEN_W-1:0] sx,
                           logic signed [PEN_W-1:0] sy, logic [CODE_W-1:0] cc);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    new_text  <= nt;
    start_x   <= sx;
    start_y   <= sy;
    char_code <= cc;
    do @(posedge clk); while (full);
  endtask

  // Hold off the sender until every predicted vertex is out, then let pen-only items settle.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (vertices_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all five registers; only called with the block drained.
  task automatic load_regs(cfg_t c);
    logic [CFG_IDX_W-1:0] idx;
    cfg_now = c;
    idx = REG_SCALE_X;
    repeat (REG_WIN_H - REG_SCALE_X + 1) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_SCALE_X: cfg_data <= CFG_DATA_W'(c.scale_x);
        REG_SCALE_Y: cfg_data <= CFG_DATA_W'(c.scale_y);
        REG_NARROW:  cfg_data <= CFG_DATA_W'(c.narrow);
        REG_FLIP:    cfg_data <= CFG_DATA_W'(c.flip);
        REG_WIN_H:   cfg_data <= CFG_DATA_W'(c.win_h);
        default:     cfg_data <= '0;
      endcase
      @(posedge clk);
      idx++;
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 11'd1024;
      3:       return SCALE_RST;
      default: return SCALE_W'($urandom_range(256, 1024));
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.scale_x = pick_scale();
    c.scale_y = pick_scale();
    c.narrow  = 1'($urandom_range(1));
    c.flip    = 1'($urandom_range(1));
    case ($urandom_range(5))
      0:       c.win_h = '0;
      1:       c.win_h = '1;
      2:       c.win_h = 13'd1;
      default: c.win_h = WIN_W'($urandom_range(1, 8191));
    endcase
    return c;
  endfunction

  initial begin : stimulus
    int  sent, sx, sy, cc;
    bit  nt;
    cfg_now       = cfg_presets[0];
    pen_x         = '0;
    pen_y         = '0;
    text_skipped  = 1'b0;
    err_count     = 0;
    quiet_cycles  = 0;
    send_idle_pct = 29;
    recv_idle_pct = 46;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: code bands, skip rules, pen and vertex clamping, register extremes.
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].cfg >= 0) begin
        drain();
        load_regs(cfg_presets[dir_tbl[i].cfg]);
      end
      table_rows_sent = {table_rows_sent, dir_tbl[i]};
      send_char(dir_tbl[i].nt, PEN_W'(dir_tbl[i].sx), PEN_W'(dir_tbl[i].sy),
                CODE_W'(dir_tbl[i].cc));
    end

    // Random part: six register settings, two per idling mode (sender 29 / receiver 46,
    // then swapped, then no idling). Mostly well-formed texts with printable bytes; the
    // rest is rows out of the window, non-printable bytes and pens near the clamp.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      load_regs(random_cfg());
      send_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 46 : 0;
      recv_idle_pct = (ph < 2) ? 46 : (ph < 4) ? 29 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        nt = (sent == 0) || ($urandom_range(7) == 0);
        case ($urandom_range(9))
          0:       sy = -int'($urandom_range(1, 8192));
          1:       sy = int'($urandom);
          default: sy = int'($urandom_range(0, cfg_now.win_h));
        endcase
        case ($urandom_range(4))
          0:       sx = PEN_TOP - int'($urandom_range(0, 300));
          1:       sx = -PEN_TOP - 1;
          default: sx = int'($urandom);
        endcase
        cc = ($urandom_range(6) == 0) ? int'($urandom)
                                      : int'($urandom_range(CHAR_FIRST, CHAR_LAST));
        send_char(nt, PEN_W'(sx), PEN_W'(sy), CODE_W'(cc));
        sent++;
        // sender holds off until the result side has caught up completely
        if (ph == 1 && sent == 40) drain();
      end
    end

    drain();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
